FILE: hw/rtl/rlsr_pkg.sv
`default_nettype none

package rlsr_pkg;

  // Fixed field widths
  localparam int MODE_W    = 3;
  localparam int ADC_W     = 14;
  localparam int CFG_W     = 16;
  localparam int CMP_W     = 16;
  localparam int LEVEL_W   = 7;
  localparam int CURSOR_W  = 2;
  localparam int SAVED_W   = 4;
  localparam int PREVIEW_W = 24;
  localparam int TICK_W    = 16;

  // Block constants
  localparam int STORE_DEPTH = 10;
  localparam int LEVEL_MAX   = 100;
  localparam int BYTE_MAX    = 255;
  localparam int PTR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int PROD_W      = ADC_W + LEVEL_W;
  localparam int STEP_W      = $clog2(LEVEL_W + 1);
  localparam int CPROD_W     = LEVEL_W + CMP_W;
  localparam int COLOR_W     = 3 * LEVEL_W;

  // Reciprocal of LEVEL_MAX for the compare division
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX));

  // Input queue; depth is a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reset values of the configuration registers
  localparam logic [ADC_W-1:0] ADC_FS_RESET      = ADC_W'(10000);
  localparam logic [CFG_W-1:0] PLAY_PERIOD_RESET = CFG_W'(500);
  localparam logic [CFG_W-1:0] PWM_PERIOD_RESET  = CFG_W'(1250);

  // Mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_ADC    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_CURSOR = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SAVE   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_PLAY   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_TICK   = MODE_W'(4);

  // Channel codes for the cursor
  localparam logic [CURSOR_W-1:0] CH_RED   = CURSOR_W'(0);
  localparam logic [CURSOR_W-1:0] CH_GREEN = CURSOR_W'(1);
  localparam logic [CURSOR_W-1:0] CH_BLUE  = CURSOR_W'(2);

  typedef enum logic [1:0] {
    CFG_ADC_FULL_SCALE = 2'd0,
    CFG_PLAY_PERIOD    = 2'd1,
    CFG_PWM_PERIOD     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_ADC,
    OP_CURSOR,
    OP_SAVE,
    OP_PLAY,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RDWAIT,
    ST_MUL,
    ST_RECIP,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADC_W-1:0]  adc_sample;
  } in_item_t;

  typedef struct packed {
    logic                 pwm_load;
    logic [CMP_W-1:0]     red_compare;
    logic [CMP_W-1:0]     green_compare;
    logic [CMP_W-1:0]     blue_compare;
    logic [LEVEL_W-1:0]   red_level;
    logic [LEVEL_W-1:0]   green_level;
    logic [LEVEL_W-1:0]   blue_level;
    logic [CURSOR_W-1:0]  cursor;
    logic [SAVED_W-1:0]   saved_count;
    logic                 playing;
    logic [PREVIEW_W-1:0] preview_color;
  } out_item_t;

  typedef struct packed {
    logic [ADC_W-1:0] adc_full_scale;
    logic [CFG_W-1:0] play_period_ticks;
    logic [CFG_W-1:0] pwm_period;
  } cfg_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    op_e               op;
    logic [PROD_W-1:0] adc_prod;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    color_t           wdata;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  typedef logic [(2**LEVEL_W)-1:0][7:0] preview_lut_t;

  // Level to preview byte, built at elaboration
  function automatic preview_lut_t build_preview_lut();
    preview_lut_t lut;
    for (int i = 0; i < 2**LEVEL_W; i++) begin
      lut[i] = 8'((i * BYTE_MAX) / LEVEL_MAX);
    end
    return lut;
  endfunction

  localparam preview_lut_t PREVIEW_LUT = build_preview_lut();

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_led_sequence_recorder.sv
// RGB LED colour mixer with a recorder of up to ten colours.
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction per
// event: ADC sample, next cursor, save colour, start playback or tick.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
// result transaction per input transaction, in order, carrying PWM compare
// values (zero unless pwm_load), the live levels, cursor, store fill,
// playback flag and the 0xRRGGBB preview.
// Configuration: cfg_we_i writes cfg_wdata_i into the register picked by
// cfg_idx_i (full scale, playback period, PWM period) at that clock edge.
// An ADC sample passes an overflow step, then one quotient bit per cycle in
// the divider. For a PWM load the three compare values are worked out one
// after another, each by a multiply and a reciprocal step, after a store
// read when a stored colour is loaded. Other events go straight to the
// result.
// The back sequencer takes one transaction at a time; a two-entry queue
// lets the front accept while it works.
// Reset clears levels, cursor, store fill, playback and the registers to
// their defaults; store contents stay undefined until saved.
// A stalled receiver holds the result in the output register; the back
// waits on it and the queue fills, then in_ready_o drops.
`default_nettype none

module rgb_led_sequence_recorder (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rlsr_pkg::in_item_t     in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rlsr_pkg::out_item_t         out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [rlsr_pkg::CFG_W-1:0] cfg_wdata_i
);

  rlsr_pkg::cfg_t     cfg_q;
  logic               cmd_valid;
  logic               cmd_ready;
  rlsr_pkg::cmd_t     cmd;
  rlsr_pkg::ram_req_t ram_req;
  rlsr_pkg::color_t   ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_full_scale    <= rlsr_pkg::ADC_FS_RESET;
      cfg_q.play_period_ticks <= rlsr_pkg::PLAY_PERIOD_RESET;
      cfg_q.pwm_period        <= rlsr_pkg::PWM_PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlsr_pkg::CFG_ADC_FULL_SCALE:
          cfg_q.adc_full_scale <= cfg_wdata_i[rlsr_pkg::ADC_W-1:0];
        rlsr_pkg::CFG_PLAY_PERIOD: cfg_q.play_period_ticks <= cfg_wdata_i;
        rlsr_pkg::CFG_PWM_PERIOD:  cfg_q.pwm_period        <= cfg_wdata_i;
        default:                   cfg_q <= cfg_q;
      endcase
    end
  end

  rlsr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rlsr_ram #(
    .WIDTH (rlsr_pkg::COLOR_W),
    .DEPTH (rlsr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  rlsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rlsr_ram.sv
`default_nettype none

module rlsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rlsr_front.sv
`default_nettype none

module rlsr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rlsr_pkg::in_item_t in_data_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output rlsr_pkg::cmd_t         cmd_o
);

  rlsr_pkg::cmd_t                     entry_q [rlsr_pkg::QUEUE_DEPTH];
  logic [rlsr_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [rlsr_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [rlsr_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  rlsr_pkg::cmd_t                     cls_cmd;
  logic                               push, pop;

  // Classify the transaction and scale the sample ahead of the divider
  always_comb begin
    cls_cmd.adc_prod = rlsr_pkg::PROD_W'(in_data_i.adc_sample) *
                       rlsr_pkg::PROD_W'(rlsr_pkg::LEVEL_MAX);
    case (in_data_i.mode)
      rlsr_pkg::MODE_ADC:    cls_cmd.op = rlsr_pkg::OP_ADC;
      rlsr_pkg::MODE_CURSOR: cls_cmd.op = rlsr_pkg::OP_CURSOR;
      rlsr_pkg::MODE_SAVE:   cls_cmd.op = rlsr_pkg::OP_SAVE;
      rlsr_pkg::MODE_PLAY:   cls_cmd.op = rlsr_pkg::OP_PLAY;
      rlsr_pkg::MODE_TICK:   cls_cmd.op = rlsr_pkg::OP_TICK;
      default:               cls_cmd.op = rlsr_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != rlsr_pkg::QCNT_W'(rlsr_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Advance queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rlsr_back.sv
`default_nettype none

module rlsr_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rlsr_pkg::cfg_t        cfg_i,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wire rlsr_pkg::cmd_t        cmd_i,
  output rlsr_pkg::ram_req_t         ram_req_o,
  input  wire rlsr_pkg::color_t      ram_rdata_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rlsr_pkg::out_item_t        out_data_o
);

  localparam logic [rlsr_pkg::LEVEL_W-1:0] LMAX = rlsr_pkg::LEVEL_W'(rlsr_pkg::LEVEL_MAX);
  localparam logic [rlsr_pkg::STEP_W-1:0]  STEP_TOP = rlsr_pkg::STEP_W'(rlsr_pkg::LEVEL_W);
  localparam logic [rlsr_pkg::TICK_W-1:0]  TICK_SAT = '1;
  localparam logic [1:0]                   CH_LAST = 2'd2;

  rlsr_pkg::back_state_e             state_q, state_d;
  rlsr_pkg::cmd_t                    cmd_q, cmd_d;
  rlsr_pkg::color_t                  live_q, live_d;
  logic [rlsr_pkg::CURSOR_W-1:0]     cursor_q, cursor_d;
  logic [rlsr_pkg::COUNT_W-1:0]      count_q, count_d;
  logic                              playing_q, playing_d;
  logic [rlsr_pkg::COUNT_W-1:0]      pos_q, pos_d;
  logic [rlsr_pkg::TICK_W-1:0]       tick_q, tick_d;
  logic [rlsr_pkg::PROD_W-1:0]       rem_q, rem_d;
  logic [rlsr_pkg::PROD_W-1:0]       dvs_q, dvs_d;
  logic [rlsr_pkg::LEVEL_W-1:0]      quo_q, quo_d;
  logic                              sat_q, sat_d;
  logic [rlsr_pkg::STEP_W-1:0]       step_q, step_d;
  logic [rlsr_pkg::LEVEL_W-1:0]      col_q [3];
  logic [rlsr_pkg::LEVEL_W-1:0]      col_d [3];
  logic [rlsr_pkg::CMP_W-1:0]        cmp_q [3];
  logic [rlsr_pkg::CMP_W-1:0]        cmp_d [3];
  logic [1:0]                        ch_q, ch_d;
  logic [rlsr_pkg::CPROD_W-1:0]      cprod_q, cprod_d;
  logic                              load_q, load_d;
  logic                              out_valid_q, out_valid_d;
  rlsr_pkg::out_item_t               out_q, out_d;

  logic [rlsr_pkg::ADC_W-1:0]        fs_eff;
  logic                              play_ok, save_ok;
  logic [rlsr_pkg::TICK_W-1:0]       tick_inc;
  logic                              tick_exp;
  logic [rlsr_pkg::COUNT_W-1:0]      pos_inc;
  logic                              play_end;
  logic                              div_ge;
  logic                              res_go;
  logic [rlsr_pkg::CPROD_W+rlsr_pkg::RECIP_W-1:0] recip_prod;
  logic [rlsr_pkg::LEVEL_W-1:0]      adc_level;

  // Shared decisions for the sequencer
  always_comb begin
    fs_eff   = (cfg_i.adc_full_scale == '0) ? rlsr_pkg::ADC_W'(1) : cfg_i.adc_full_scale;
    play_ok  = (count_q != '0) && !playing_q;
    save_ok  = (count_q < rlsr_pkg::COUNT_W'(rlsr_pkg::STORE_DEPTH));
    tick_inc = (tick_q != TICK_SAT) ? tick_q + 1'b1 : tick_q;
    tick_exp = (tick_inc >= cfg_i.play_period_ticks);
    pos_inc  = pos_q + 1'b1;
    play_end = (pos_inc >= count_q);
    div_ge   = (rem_q >= dvs_q);
    res_go   = !out_valid_q || out_ready_i;
    recip_prod = (rlsr_pkg::CPROD_W + rlsr_pkg::RECIP_W)'(cprod_q) *
                 (rlsr_pkg::CPROD_W + rlsr_pkg::RECIP_W)'(rlsr_pkg::RECIP);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlsr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = rlsr_pkg::ST_EXEC;
        end
      end
      rlsr_pkg::ST_EXEC: begin
        case (cmd_q.op)
          rlsr_pkg::OP_ADC:  state_d = rlsr_pkg::ST_DIV;
          rlsr_pkg::OP_SAVE: state_d = rlsr_pkg::ST_MUL;
          rlsr_pkg::OP_PLAY: state_d = play_ok ? rlsr_pkg::ST_RDWAIT : rlsr_pkg::ST_RESULT;
          rlsr_pkg::OP_TICK: begin
            if (playing_q && tick_exp) begin
              state_d = play_end ? rlsr_pkg::ST_MUL : rlsr_pkg::ST_RDWAIT;
            end else begin
              state_d = rlsr_pkg::ST_RESULT;
            end
          end
          default: state_d = rlsr_pkg::ST_RESULT;
        endcase
      end
      rlsr_pkg::ST_DIV: begin
        if (step_q == '0) begin
          state_d = rlsr_pkg::ST_RESULT;
        end
      end
      rlsr_pkg::ST_RDWAIT: state_d = rlsr_pkg::ST_MUL;
      rlsr_pkg::ST_MUL:    state_d = rlsr_pkg::ST_RECIP;
      rlsr_pkg::ST_RECIP:  state_d = (ch_q == CH_LAST) ? rlsr_pkg::ST_RESULT : rlsr_pkg::ST_MUL;
      rlsr_pkg::ST_RESULT: begin
        if (res_go) begin
          state_d = rlsr_pkg::ST_IDLE;
        end
      end
      default: state_d = rlsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the queue and the store
  always_comb begin
    cmd_ready_o     = (state_q == rlsr_pkg::ST_IDLE);
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = count_q[rlsr_pkg::PTR_W-1:0];
    ram_req_o.wdata = live_q;
    ram_req_o.raddr = '0;
    if (state_q == rlsr_pkg::ST_EXEC) begin
      case (cmd_q.op)
        rlsr_pkg::OP_SAVE: ram_req_o.we    = save_ok;
        rlsr_pkg::OP_TICK: ram_req_o.raddr = pos_inc[rlsr_pkg::PTR_W-1:0];
        default:           ram_req_o.raddr = '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Datapath
  always_comb begin
    cmd_d       = cmd_q;
    live_d      = live_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    playing_d   = playing_q;
    pos_d       = pos_q;
    tick_d      = tick_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    sat_d       = sat_q;
    step_d      = step_q;
    col_d       = col_q;
    cmp_d       = cmp_q;
    ch_d        = ch_q;
    cprod_d     = cprod_q;
    load_d      = load_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    adc_level   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rlsr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
        end
      end
      rlsr_pkg::ST_EXEC: begin
        load_d = 1'b0;
        ch_d   = '0;
        col_d[0] = live_q.red;
        col_d[1] = live_q.green;
        col_d[2] = live_q.blue;
        case (cmd_q.op)
          rlsr_pkg::OP_ADC: begin
            rem_d  = cmd_q.adc_prod;
            dvs_d  = {fs_eff, {rlsr_pkg::LEVEL_W{1'b0}}};
            quo_d  = '0;
            sat_d  = 1'b0;
            step_d = STEP_TOP;
          end
          rlsr_pkg::OP_CURSOR: begin
            cursor_d = (cursor_q == rlsr_pkg::CH_BLUE) ? rlsr_pkg::CH_RED : cursor_q + 1'b1;
          end
          rlsr_pkg::OP_SAVE: begin
            if (save_ok) begin
              count_d = count_q + 1'b1;
            end
            load_d = 1'b1;
          end
          rlsr_pkg::OP_PLAY: begin
            if (play_ok) begin
              playing_d = 1'b1;
              pos_d     = '0;
              tick_d    = '0;
              load_d    = 1'b1;
            end
          end
          rlsr_pkg::OP_TICK: begin
            if (playing_q) begin
              if (tick_exp) begin
                tick_d = '0;
                pos_d  = pos_inc;
                load_d = 1'b1;
                if (play_end) begin
                  playing_d = 1'b0;
                end
              end else begin
                tick_d = tick_inc;
              end
            end
          end
          default: load_d = 1'b0;
        endcase
      end
      rlsr_pkg::ST_DIV: begin
        // One quotient bit per cycle; the top step only detects overflow
        if (step_q == STEP_TOP) begin
          sat_d = div_ge;
        end else begin
          if (div_ge) begin
            rem_d = rem_q - dvs_q;
          end
          quo_d = {quo_q[rlsr_pkg::LEVEL_W-2:0], div_ge};
        end
        dvs_d  = dvs_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          adc_level = (sat_d || (quo_d > LMAX)) ? LMAX : quo_d;
          case (cursor_q)
            rlsr_pkg::CH_RED:   live_d.red   = adc_level;
            rlsr_pkg::CH_GREEN: live_d.green = adc_level;
            default:            live_d.blue  = adc_level;
          endcase
        end
      end
      rlsr_pkg::ST_RDWAIT: begin
        col_d[0] = ram_rdata_i.red;
        col_d[1] = ram_rdata_i.green;
        col_d[2] = ram_rdata_i.blue;
      end
      rlsr_pkg::ST_MUL: begin
        cprod_d = rlsr_pkg::CPROD_W'(LMAX - col_q[ch_q]) *
                  rlsr_pkg::CPROD_W'(cfg_i.pwm_period);
      end
      rlsr_pkg::ST_RECIP: begin
        cmp_d[ch_q] = recip_prod[rlsr_pkg::RECIP_SHIFT +: rlsr_pkg::CMP_W];
        ch_d        = ch_q + 1'b1;
      end
      rlsr_pkg::ST_RESULT: begin
        if (res_go) begin
          out_valid_d         = 1'b1;
          out_d.pwm_load      = load_q;
          out_d.red_compare   = load_q ? cmp_q[0] : '0;
          out_d.green_compare = load_q ? cmp_q[1] : '0;
          out_d.blue_compare  = load_q ? cmp_q[2] : '0;
          out_d.red_level     = live_q.red;
          out_d.green_level   = live_q.green;
          out_d.blue_level    = live_q.blue;
          out_d.cursor        = cursor_q;
          out_d.saved_count   = rlsr_pkg::SAVED_W'(count_q);
          out_d.playing       = playing_q;
          out_d.preview_color = {rlsr_pkg::PREVIEW_LUT[live_q.red],
                                 rlsr_pkg::PREVIEW_LUT[live_q.green],
                                 rlsr_pkg::PREVIEW_LUT[live_q.blue]};
        end
      end
      default: load_d = load_q;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlsr_pkg::ST_IDLE;
      live_q      <= '0;
      cursor_q    <= rlsr_pkg::CH_RED;
      count_q     <= '0;
      playing_q   <= 1'b0;
      pos_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      playing_q   <= playing_d;
      pos_q       <= pos_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    sat_q   <= sat_d;
    step_q  <= step_d;
    col_q   <= col_d;
    cmp_q   <= cmp_d;
    ch_q    <= ch_d;
    cprod_q <= cprod_d;
    load_q  <= load_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire
